// ===== hdl/sis_pkg.sv =====
// Shared types and constants for the segment intersection check.
package sis_pkg;

	// Width of the same-point distance register
	localparam int CFG_W = 31;

	// Which rule decided the result
	typedef enum logic [2:0] {
		RULE_SHARED   = 3'd0,
		RULE_OVERLAP  = 3'd1,
		RULE_PARALLEL = 3'd2,
		RULE_CROSS    = 3'd3,
		RULE_MISS     = 3'd4
	} rule_t;

endpackage

// ===== hdl/sis_ifs.sv =====
// Valid/ready channel interfaces: segment pairs in, results out, threshold writes.
interface sis_in_if #(parameter int COORD_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] first_start_x;
	logic signed [COORD_WIDTH-1:0] first_start_y;
	logic signed [COORD_WIDTH-1:0] first_end_x;
	logic signed [COORD_WIDTH-1:0] first_end_y;
	logic signed [COORD_WIDTH-1:0] second_start_x;
	logic signed [COORD_WIDTH-1:0] second_start_y;
	logic signed [COORD_WIDTH-1:0] second_end_x;
	logic signed [COORD_WIDTH-1:0] second_end_y;

	modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
		second_start_x, second_start_y, second_end_x, second_end_y, input ready);
	modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
		second_start_x, second_start_y, second_end_x, second_end_y, output ready);
endinterface

interface sis_out_if #(parameter int COORD_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic signed [COORD_WIDTH-1:0] meet_x;
	logic signed [COORD_WIDTH-1:0] meet_y;
	logic [2:0]                    rule_fired;

	modport source (output valid, hit, meet_x, meet_y, rule_fired, input ready);
	modport sink (input valid, hit, meet_x, meet_y, rule_fired, output ready);
endinterface

interface sis_cfg_if;
	import sis_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] same_point_distance;

	modport source (output valid, same_point_distance, input ready);
	modport sink (input valid, same_point_distance, output ready);
endinterface

// ===== hdl/sis_sqrt.sv =====
// Pipelined integer square root, one root bit per stage (floor result).
module sis_sqrt #(
	parameter int IN_W = 66
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   radicand,
	output logic [IN_W/2-1:0] root
);
	localparam int OUT_W = IN_W / 2;
	localparam int REM_W = OUT_W + 2;

	logic [IN_W-1:0]  rad_s  [OUT_W];
	logic [REM_W-1:0] rem_s  [OUT_W];
	logic [OUT_W-1:0] root_s [OUT_W];

	for (genvar i = 0; i < OUT_W; i++) begin : g_stage
		logic [IN_W-1:0]  rad_in;
		logic [REM_W-1:0] rem_in;
		logic [OUT_W-1:0] root_in;
		logic [REM_W+1:0] rem_try;
		logic [REM_W+1:0] trial;

		if (i == 0) begin : g_first
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
		end

		// bring down two radicand bits, try 4*root+1
		assign rem_try = {rem_in, rad_in[IN_W-1 -: 2]};
		assign trial   = (REM_W+2)'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i] <= rad_in << 2;
				if (rem_try >= trial) begin
					rem_s[i]  <= REM_W'(rem_try - trial);
					root_s[i] <= {root_in[OUT_W-2:0], 1'b1};
				end else begin
					rem_s[i]  <= REM_W'(rem_try);
					root_s[i] <= {root_in[OUT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[OUT_W-1];

endmodule

// ===== hdl/sis_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with a sideband bit.
module sis_div #(
	parameter int D_W = 66,
	parameter int Q_W = 33
) (
	input  logic               clk,
	input  logic               en,
	input  logic [D_W+Q_W-1:0] num,
	input  logic [D_W-1:0]     den,
	input  logic               side_in,
	output logic [Q_W-1:0]     quo,
	output logic               side_out
);
	// quotient must fit Q_W bits, so the high part of num starts below den
	logic [D_W-1:0] rem_s  [Q_W];
	logic [Q_W-1:0] lo_s   [Q_W];
	logic [D_W-1:0] den_s  [Q_W];
	logic [Q_W-1:0] quo_s  [Q_W];
	logic           side_s [Q_W];

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic [D_W-1:0] rem_in;
		logic [Q_W-1:0] lo_in;
		logic [D_W-1:0] den_in;
		logic [Q_W-1:0] quo_in;
		logic           side_i;
		logic [D_W:0]   rem_try;

		if (i == 0) begin : g_first
			assign rem_in = num[D_W+Q_W-1:Q_W];
			assign lo_in  = num[Q_W-1:0];
			assign den_in = den;
			assign quo_in = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign lo_in  = lo_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
			assign side_i = side_s[i-1];
		end

		assign rem_try = {rem_in, lo_in[Q_W-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				lo_s[i]   <= lo_in << 1;
				den_s[i]  <= den_in;
				side_s[i] <= side_i;
				if (rem_try >= {1'b0, den_in}) begin
					rem_s[i] <= D_W'(rem_try - {1'b0, den_in});
					quo_s[i] <= {quo_in[Q_W-2:0], 1'b1};
				end else begin
					rem_s[i] <= D_W'(rem_try);
					quo_s[i] <= {quo_in[Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo      = quo_s[Q_W-1];
	assign side_out = side_s[Q_W-1];

endmodule

// ===== hdl/segment_intersection_check.sv =====
// Top level: pipelined 2D segment intersection check with rule reporting.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+------------------------------------------
//  seg     | in  | valid/ready  | two segments, start/end points, Q format
//  res     | out | valid/ready  | hit, meet_x, meet_y, rule_fired
//  cfg     | in  | valid/ready  | same_point_distance (always ready)
//
// One segment pair per cycle while no result waits untaken; the square root and divide
// pipelines resolve one result bit per stage.
// Reset clears all valid bits and loads the threshold with 0.01 in fixed point.
// When a result waits untaken, the whole pipe holds and seg.ready drops.
module segment_intersection_check #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input logic    clk,
	input logic    arst_n,
	sis_in_if.sink seg,
	sis_out_if.source res,
	sis_cfg_if.sink cfg
);
	import sis_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int D   = W + 1;          // coordinate difference
	localparam int D2  = 2 * D;          // product / squared sum
	localparam int X   = 2 * D + 1;      // cross product
	localparam int K   = D;              // root and quotient width
	localparam int LAT = K + 7;
	localparam int TW  = ((K > CFG_W) ? K : CFG_W) + 2;
	localparam logic [CFG_W-1:0] SPD_RESET = CFG_W'((64'd1 << FRAC_BITS) / 100);

	// point pairs: ab ac ad bc bd cd
	localparam int PA [6] = '{0, 0, 0, 1, 1, 2};
	localparam int PB [6] = '{1, 2, 3, 2, 3, 3};
	// crosses u.y*v.x - v.y*u.x: four collinear tests, den, s, t
	localparam int CU [7] = '{0, 0, 5, 5, 5, 0, 5};
	localparam int CV [7] = '{3, 4, 2, 4, 0, 1, 1};

	typedef struct packed {
		logic [7:0][W-1:0] pt;
		logic [3:0]        col;
		logic              par;
		logic              acc;
	} side_t;

	logic             adv;
	logic [LAT:1]     vld_s;
	logic [CFG_W-1:0] spd_q;

	logic [7:0][W-1:0]    pt_s1, pt_s2, pt_s3;
	logic signed [D-1:0]  dif_s1 [6][2];
	logic signed [D2-1:0] sq_s2  [6][2];
	logic signed [D2-1:0] cp_s2  [7][2];
	logic signed [D-1:0]  l1_s2  [2];
	logic signed [D-1:0]  l1_s3  [2];
	logic [D2-1:0]        sumsq_s3 [6];
	logic [3:0]           col_s3;
	logic signed [X-1:0]  den_s3, sv_s3, tv_s3;

	logic                 par_c, dpos_c, rej_c;
	logic [D2-1:0]        tmag_s4, dmag_s4, dmag_s5, dmag_s6;
	logic [D-1:0]         l1mag_s4 [2];
	logic [1:0]           qneg_s4, qneg_s5, qneg_s6, qneg_sc;
	logic [D2-1:0]        pp_s5 [2][2];
	logic [D2+D-1:0]      num_s6 [2];
	logic [K-1:0]         quo_sc [2];

	side_t                side_s [4:K+3];
	logic [K-1:0]         root_c  [6];
	logic [K-1:0]         root_sa [6];
	logic [5:0]           same_sa;
	side_t                side_sa, side_sb;
	logic [3:0]           sh_sb, ov_sb;
	rule_t                rule_sc, rule_so;
	logic [1:0][W-1:0]    sel_sc;
	logic                 hit_so;
	logic [1:0][W-1:0]    meet_so;
	logic [D:0]           meet_c [2];

	// point C on segment AB by the distance-sum rule
	function automatic logic on_seg(logic near_b, logic near_a, logic [K-1:0] d1,
		logic [K-1:0] d2, logic [K-1:0] d3, logic [CFG_W-1:0] th);
		logic [TW-1:0] s12;
		s12 = TW'(d1) + TW'(d2);
		return near_b | (~near_a & (s12 <= TW'(d3) + TW'(th)) & (s12 + TW'(th) >= TW'(d3)));
	endfunction

	// coordinate by flat index: ax ay bx by cx cy dx dy
	function automatic logic [W-1:0] seg_pt(int idx);
		logic [W-1:0] v;
		case (idx)
			0: v = seg.first_start_x;
			1: v = seg.first_start_y;
			2: v = seg.first_end_x;
			3: v = seg.first_end_y;
			4: v = seg.second_start_x;
			5: v = seg.second_start_y;
			6: v = seg.second_end_x;
			default: v = seg.second_end_y;
		endcase
		return v;
	endfunction

	// whole pipe moves unless a result waits at the output
	assign adv       = ~vld_s[LAT] | res.ready;
	assign seg.ready = adv;
	assign res.valid = vld_s[LAT];
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			spd_q <= SPD_RESET;
		end else begin
			if (adv) begin
				vld_s <= {vld_s[LAT-1:1], seg.valid};
			end
			if (cfg.valid) begin
				spd_q <= cfg.same_point_distance;
			end
		end
	end

	// s1: capture points, form the pair differences
	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1 <= {seg.second_end_y, seg.second_end_x, seg.second_start_y,
				seg.second_start_x, seg.first_end_y, seg.first_end_x,
				seg.first_start_y, seg.first_start_x};
			for (int i = 0; i < 6; i++) begin
				for (int a = 0; a < 2; a++) begin
					dif_s1[i][a] <= D'(signed'(seg_pt(2 * PB[i] + a)))
						- D'(signed'(seg_pt(2 * PA[i] + a)));
				end
			end
		end
	end

	// s2: squares and cross-product terms
	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s2 <= pt_s1;
			l1_s2 <= dif_s1[0];
			for (int i = 0; i < 6; i++) begin
				for (int a = 0; a < 2; a++) begin
					sq_s2[i][a] <= dif_s1[i][a] * dif_s1[i][a];
				end
			end
			for (int k = 0; k < 7; k++) begin
				cp_s2[k][0] <= dif_s1[CU[k]][1] * dif_s1[CV[k]][0];
				cp_s2[k][1] <= dif_s1[CV[k]][1] * dif_s1[CU[k]][0];
			end
		end
	end

	// s3: squared distances, collinear flags, den/s/t
	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s3 <= pt_s2;
			l1_s3 <= l1_s2;
			for (int i = 0; i < 6; i++) begin
				sumsq_s3[i] <= D2'($unsigned(sq_s2[i][0]) + $unsigned(sq_s2[i][1]));
			end
			for (int k = 0; k < 4; k++) begin
				col_s3[k] <= (cp_s2[k][0] == cp_s2[k][1]);
			end
			den_s3 <= X'(cp_s2[4][0]) - X'(cp_s2[4][1]);
			sv_s3  <= X'(cp_s2[5][0]) - X'(cp_s2[5][1]);
			tv_s3  <= X'(cp_s2[6][0]) - X'(cp_s2[6][1]);
		end
	end

	// parallel and crossing window tests
	assign par_c  = (den_s3 == '0);
	assign dpos_c = ~den_s3[X-1];
	assign rej_c  = (sv_s3[X-1] == dpos_c) | (tv_s3[X-1] == dpos_c)
		| ((sv_s3 > den_s3) == dpos_c) | ((tv_s3 > den_s3) == dpos_c);

	// s4: magnitudes and quotient signs
	always_ff @(posedge clk) begin
		if (adv) begin
			tmag_s4 <= tv_s3[X-1] ? D2'(-tv_s3) : D2'(tv_s3);
			dmag_s4 <= den_s3[X-1] ? D2'(-den_s3) : D2'(den_s3);
			for (int a = 0; a < 2; a++) begin
				l1mag_s4[a] <= l1_s3[a][D-1] ? D'(-l1_s3[a]) : D'(l1_s3[a]);
				qneg_s4[a]  <= tv_s3[X-1] ^ l1_s3[a][D-1] ^ den_s3[X-1];
			end
		end
	end

	// s5: |t| * |l1| in two partial products per axis
	always_ff @(posedge clk) begin
		if (adv) begin
			dmag_s5 <= dmag_s4;
			qneg_s5 <= qneg_s4;
			for (int a = 0; a < 2; a++) begin
				pp_s5[a][0] <= tmag_s4[D-1:0] * l1mag_s4[a];
				pp_s5[a][1] <= tmag_s4[D2-1:D] * l1mag_s4[a];
			end
		end
	end

	// s6: combine partial products into the dividend
	always_ff @(posedge clk) begin
		if (adv) begin
			dmag_s6 <= dmag_s5;
			qneg_s6 <= qneg_s5;
			for (int a = 0; a < 2; a++) begin
				num_s6[a] <= (D2+D)'(pp_s5[a][0]) + {pp_s5[a][1], D'(0)};
			end
		end
	end

	for (genvar a = 0; a < 2; a++) begin : g_div
		sis_div #(.D_W(D2), .Q_W(K)) u_div (
			.clk      (clk),
			.en       (adv),
			.num      (num_s6[a]),
			.den      (dmag_s6),
			.side_in  (qneg_s6[a]),
			.quo      (quo_sc[a]),
			.side_out (qneg_sc[a])
		);
	end

	// six pair distances
	for (genvar i = 0; i < 6; i++) begin : g_sqrt
		sis_sqrt #(.IN_W(D2)) u_sqrt (
			.clk      (clk),
			.en       (adv),
			.radicand (sumsq_s3[i]),
			.root     (root_c[i])
		);
	end

	// carry points and flags alongside the square roots
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[4] <= '{pt: pt_s3, col: col_s3, par: par_c, acc: ~rej_c};
			for (int j = 5; j <= K + 3; j++) begin
				side_s[j] <= side_s[j-1];
			end
		end
	end

	// sa: same-point flags
	always_ff @(posedge clk) begin
		if (adv) begin
			side_sa <= side_s[K+3];
			for (int i = 0; i < 6; i++) begin
				root_sa[i] <= root_c[i];
				same_sa[i] <= TW'(root_c[i]) < TW'(spd_q);
			end
		end
	end

	// sb: shared endpoints and collinear overlaps
	always_ff @(posedge clk) begin
		if (adv) begin
			side_sb  <= side_sa;
			sh_sb[0] <= same_sa[4] & ~same_sa[1];
			sh_sb[1] <= same_sa[3] & ~same_sa[2];
			sh_sb[2] <= same_sa[1] & ~same_sa[4];
			sh_sb[3] <= same_sa[2] & ~same_sa[3];
			ov_sb[0] <= side_sa.col[0] & on_seg(same_sa[3], same_sa[1],
				root_sa[1], root_sa[3], root_sa[0], spd_q);
			ov_sb[1] <= side_sa.col[1] & on_seg(same_sa[4], same_sa[2],
				root_sa[2], root_sa[4], root_sa[0], spd_q);
			ov_sb[2] <= side_sa.col[2] & on_seg(same_sa[2], same_sa[1],
				root_sa[1], root_sa[2], root_sa[5], spd_q);
			ov_sb[3] <= side_sa.col[3] & on_seg(same_sa[4], same_sa[3],
				root_sa[3], root_sa[4], root_sa[5], spd_q);
		end
	end

	// sc: rule priority and candidate point
	always_ff @(posedge clk) begin
		if (adv) begin
			if (sh_sb[0] | sh_sb[1]) begin
				rule_sc <= RULE_SHARED;
				sel_sc  <= {side_sb.pt[3], side_sb.pt[2]};
			end else if (sh_sb[2] | sh_sb[3]) begin
				rule_sc <= RULE_SHARED;
				sel_sc  <= {side_sb.pt[1], side_sb.pt[0]};
			end else if (ov_sb[0]) begin
				rule_sc <= RULE_OVERLAP;
				sel_sc  <= {side_sb.pt[5], side_sb.pt[4]};
			end else if (ov_sb[1]) begin
				rule_sc <= RULE_OVERLAP;
				sel_sc  <= {side_sb.pt[7], side_sb.pt[6]};
			end else if (ov_sb[2]) begin
				rule_sc <= RULE_OVERLAP;
				sel_sc  <= {side_sb.pt[1], side_sb.pt[0]};
			end else if (ov_sb[3]) begin
				rule_sc <= RULE_OVERLAP;
				sel_sc  <= {side_sb.pt[3], side_sb.pt[2]};
			end else if (side_sb.par) begin
				rule_sc <= RULE_PARALLEL;
				sel_sc  <= '0;
			end else if (side_sb.acc) begin
				rule_sc <= RULE_CROSS;
				sel_sc  <= {side_sb.pt[1], side_sb.pt[0]};
			end else begin
				rule_sc <= RULE_MISS;
				sel_sc  <= '0;
			end
		end
	end

	// crossing point: start of first segment plus signed quotient
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			if (qneg_sc[a]) begin
				meet_c[a] = (D+1)'(signed'(sel_sc[a])) - (D+1)'(quo_sc[a]);
			end else begin
				meet_c[a] = (D+1)'(signed'(sel_sc[a])) + (D+1)'(quo_sc[a]);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			rule_so <= rule_sc;
			hit_so  <= (rule_sc == RULE_SHARED) | (rule_sc == RULE_OVERLAP)
				| (rule_sc == RULE_CROSS);
			if (rule_sc == RULE_CROSS) begin
				meet_so <= {meet_c[1][W-1:0], meet_c[0][W-1:0]};
			end else begin
				meet_so <= sel_sc;
			end
		end
	end

	assign res.hit        = hit_so;
	assign res.meet_x     = meet_so[0];
	assign res.meet_y     = meet_so[1];
	assign res.rule_fired = rule_so;

endmodule
